// ===== sv/ipid_pkg.sv =====
// Shared types, constants and helpers for the incremental PID wheel speed block.
`default_nettype none

package ipid_pkg;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_UPPER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOWER = 3'd5;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [15:0]        GAIN_P_RESET     = 16'd17920;  // 70.0 in Q8.8
  localparam logic [15:0]        GAIN_I_RESET     = 16'd2048;   // 8.0 in Q8.8
  localparam logic [15:0]        GAIN_D_RESET     = 16'd0;
  localparam logic signed [3:0]  STEER_RESET      = 4'sd0;
  localparam logic [14:0]        DUTY_UPPER_RESET = 15'd8000;
  localparam logic signed [15:0] DUTY_LOWER_RESET = -16'sd3000;

  localparam int NUM_WHEELS = 2;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic signed [3:0]  steer_factor;
    logic [14:0]        duty_upper;
    logic signed [15:0] duty_lower;
  } ipid_cfg_t;

  // Request after goal scaling and error calculation
  typedef struct packed {
    logic               wheel;
    logic signed [15:0] err;
  } ipid_err_t;

  // Result of one control update
  typedef struct packed {
    logic               wheel_out;
    logic signed [15:0] duty;
    logic [15:0]        pwm_magnitude;
    logic               reverse;
  } ipid_res_t;

  // Saturate a signed value to the 16-bit signed range
  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ipid_err.sv =====
// Goal scaling by the steering factor and saturated speed error.
`default_nettype none

module ipid_err (
  input  wire logic                  wheel,
  input  wire logic signed [15:0]    speed_goal,
  input  wire logic signed [15:0]    encoder_count,
  input  wire logic signed [3:0]     steer_factor,
  output ipid_pkg::ipid_err_t        err_out
);
  import ipid_pkg::*;

  logic signed [4:0]  steer_ext;
  logic signed [4:0]  scale;
  logic signed [20:0] goal_prod;
  logic signed [15:0] goal_sat;
  logic signed [16:0] err_raw;

  // Left wheel takes (1 - f), right wheel (1 + f)
  assign steer_ext = {steer_factor[3], steer_factor};
  assign scale     = wheel ? (5'sd1 + steer_ext) : (5'sd1 - steer_ext);

  // Scale the goal and clip it, then form the clipped error
  assign goal_prod = 21'(speed_goal) * 21'(scale);
  assign goal_sat  = sat16(22'(goal_prod));
  assign err_raw   = 17'(goal_sat) - 17'(encoder_count);

  assign err_out.wheel = wheel;
  assign err_out.err   = sat16(22'(err_raw));

endmodule

`default_nettype wire

// ===== sv/ipid_core.sv =====
// Velocity-form PID update with per-wheel error history, duty and direction.
`default_nettype none

module ipid_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ipid_pkg::ipid_cfg_t cfg,
  input  wire ipid_pkg::ipid_err_t req,
  input  wire logic                update,
  output ipid_pkg::ipid_res_t      res
);
  import ipid_pkg::*;

  // Per-wheel state
  logic signed [15:0] err_prev  [NUM_WHEELS];
  logic signed [15:0] err_prev2 [NUM_WHEELS];
  logic signed [15:0] duty_acc  [NUM_WHEELS];
  logic               dir_hold  [NUM_WHEELS];

  logic signed [15:0] e1;
  logic signed [15:0] e2;
  logic signed [15:0] acc;
  logic               dir_old;
  logic signed [16:0] diff_p;
  logic signed [17:0] diff_d;
  logic signed [33:0] prod_p;
  logic signed [32:0] prod_i;
  logic signed [34:0] prod_d;
  logic signed [36:0] sum;
  logic signed [36:0] sum_adj;
  logic signed [28:0] inc;
  logic signed [29:0] nd;
  logic signed [29:0] nd_hi;
  logic signed [29:0] upper_ext;
  logic signed [29:0] lower_ext;
  logic signed [15:0] duty_new;
  logic               dir_new;

  assign e1      = err_prev[req.wheel];
  assign e2      = err_prev2[req.wheel];
  assign acc     = duty_acc[req.wheel];
  assign dir_old = dir_hold[req.wheel];

  // Proportional and derivative differences
  assign diff_p = 17'(req.err) - 17'(e1);
  assign diff_d = 18'(req.err) - (18'(e1) <<< 1) + 18'(e2);

  // Three gain products in parallel
  assign prod_p = 34'($signed({1'b0, cfg.gain_p})) * 34'(diff_p);
  assign prod_i = 33'($signed({1'b0, cfg.gain_i})) * 33'(req.err);
  assign prod_d = 35'($signed({1'b0, cfg.gain_d})) * 35'(diff_d);

  assign sum = 37'(prod_p) + 37'(prod_i) + 37'(prod_d);

  // Drop the Q8.8 fraction, rounding toward zero
  assign sum_adj = sum[36] ? (sum + 37'sd255) : sum;
  assign inc     = 29'(sum_adj >>> 8);

  // Accumulate, clip to the upper limit and then to the lower one
  assign nd        = 30'(acc) + 30'(inc);
  assign upper_ext = $signed({15'd0, cfg.duty_upper});
  assign lower_ext = 30'(cfg.duty_lower);
  assign nd_hi     = (nd > upper_ext) ? upper_ext : nd;
  assign duty_new  = (nd_hi < lower_ext) ? cfg.duty_lower : nd_hi[15:0];

  // Keep the previous direction while the duty is zero
  assign dir_new = (duty_new != 16'sd0) ? duty_new[15] : dir_old;

  assign res.wheel_out     = req.wheel;
  assign res.duty          = duty_new;
  assign res.pwm_magnitude = duty_new[15] ? (16'd0 - 16'(duty_new)) : 16'(duty_new);
  assign res.reverse       = dir_new;

  // Commit the state as the result leaves for the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        err_prev[w]  <= '0;
        err_prev2[w] <= '0;
        duty_acc[w]  <= '0;
        dir_hold[w]  <= 1'b0;
      end
    end else if (update) begin
      err_prev2[req.wheel] <= e1;
      err_prev[req.wheel]  <= req.err;
      duty_acc[req.wheel]  <= duty_new;
      dir_hold[req.wheel]  <= dir_new;
    end
  end

endmodule

`default_nettype wire

// ===== sv/incremental_pid_wheel_speed.sv =====
// Top level of the two-wheel incremental PID speed controller.
// Usage:
//   Input stream (s_*): one request per control period for one wheel.
//   s_tuser carries the wheel (0 left, 1 right); s_tdata carries the speed
//   goal and the measured encoder count. Output stream (m_*): exactly one
//   result per request, in order: wheel in m_tuser, duty, PWM magnitude and
//   direction bit in m_tdata.
//   A request accepted into the input register moves on into the output
//   register and is then shown on m_tvalid.
//   Throughput: one request per cycle unless stalled, both wheels freely
//   interleaved; per-wheel state is written as a result enters the output
//   register, so a following request for the same wheel sees it at once.
//   The path from the input register to the output register holds the
//   three gain multiplies, their sum and the duty clip.
//   Stall: when m_tready is low the result holds in the output register and
//   one more request may wait in the input register; s_tready then drops.
//   Reset (synchronous, rst high) empties both registers, clears the error
//   history, duty and direction of both wheels and loads the default gains
//   and limits. Configuration is written through cfg_we / cfg_index /
//   cfg_data while no request is in flight; unknown indexes are ignored.
`default_nettype none

module incremental_pid_wheel_speed (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  input  wire logic [31:0]                       s_tdata,  // speed_goal, encoder_count
  input  wire logic                              s_tuser,  // wheel
  // Output stream
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  output      logic [39:0]                       m_tdata,  // duty, pwm_magnitude, reverse
  output      logic                              m_tuser,  // wheel_out
  // Configuration
  input  wire logic                              cfg_we,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ipid_pkg::*;

  ipid_cfg_t cfg;
  ipid_err_t err_in;
  ipid_err_t stage;
  logic      stage_valid;
  ipid_res_t res;
  ipid_res_t out_res;
  logic      out_valid;
  logic      out_free;
  logic      advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p       <= GAIN_P_RESET;
      cfg.gain_i       <= GAIN_I_RESET;
      cfg.gain_d       <= GAIN_D_RESET;
      cfg.steer_factor <= STEER_RESET;
      cfg.duty_upper   <= DUTY_UPPER_RESET;
      cfg.duty_lower   <= DUTY_LOWER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:     cfg.gain_p       <= cfg_data;
        CFG_GAIN_I:     cfg.gain_i       <= cfg_data;
        CFG_GAIN_D:     cfg.gain_d       <= cfg_data;
        CFG_STEER:      cfg.steer_factor <= cfg_data[3:0];
        CFG_DUTY_UPPER: cfg.duty_upper   <= cfg_data[14:0];
        CFG_DUTY_LOWER: cfg.duty_lower   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Scale the goal and form the error on the way into the input register
  ipid_err u_err (
    .wheel         (s_tuser),
    .speed_goal    (s_tdata[15:0]),
    .encoder_count (s_tdata[31:16]),
    .steer_factor  (cfg.steer_factor),
    .err_out       (err_in)
  );

  // Move a request on when the output register is empty or being emptied
  assign out_free = !out_valid || m_tready;
  assign advance  = stage_valid && out_free;
  assign s_tready = !stage_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stage <= err_in;
    end
  end

  ipid_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .req    (stage),
    .update (advance),
    .res    (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.wheel_out;
  assign m_tdata  = {7'd0, out_res.reverse, out_res.pwm_magnitude, out_res.duty};

endmodule

`default_nettype wire

// ===== sv/ipid_chk.sv =====
// Port-level checks for the incremental PID wheel speed block, bound to the top level.
`default_nettype none

module ipid_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  logic signed [15:0] duty;
  logic [15:0]        mag;
  logic               rev;

  assign duty = m_tdata[15:0];
  assign mag  = m_tdata[31:16];
  assign rev  = m_tdata[32];

  // Magnitude must be the absolute value of the duty shown with it
  a_mag_abs: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (mag == (duty[15] ? (16'd0 - 16'(duty)) : 16'(duty))))
    else $error("pwm magnitude does not match duty");

  // Direction follows the sign of a non-zero duty
  a_dir_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (duty != 16'sd0)) |-> (rev == duty[15]))
    else $error("direction bit disagrees with duty sign");

  // An empty output register never holds back the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind incremental_pid_wheel_speed ipid_chk u_ipid_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/tb_incremental_pid_wheel_speed.sv =====
// Self-checking testbench for the two-wheel incremental PID speed controller.
`timescale 1ns / 1ps

module tb_incremental_pid_wheel_speed;
  import ipid_pkg::*;

  // Register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 142;

  // Per-wheel duty predictor with its own copy of gains, limits and history
  class duty_predictor;
    longint gain_p, gain_i, gain_d, steer, upper, lower;
    longint err1[NUM_WHEELS], err2[NUM_WHEELS], acc[NUM_WHEELS];
    bit     dir[NUM_WHEELS];
    ipid_res_t duty_due[$];
    int     mismatches;

    function new();
      gain_p = longint'(GAIN_P_RESET);
      gain_i = longint'(GAIN_I_RESET);
      gain_d = longint'(GAIN_D_RESET);
      steer  = longint'(STEER_RESET);
      upper  = longint'(DUTY_UPPER_RESET);
      lower  = longint'(DUTY_LOWER_RESET);
      for (int w = 0; w < NUM_WHEELS; w++) begin
        err1[w] = 0;
        err2[w] = 0;
        acc[w]  = 0;
        dir[w]  = 1'b0;
      end
      mismatches = 0;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_P:     gain_p = longint'(data);
        CFG_GAIN_I:     gain_i = longint'(data);
        CFG_GAIN_D:     gain_d = longint'(data);
        CFG_STEER:      steer  = longint'(signed'(data[3:0]));
        CFG_DUTY_UPPER: upper  = longint'(data[14:0]);
        CFG_DUTY_LOWER: lower  = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    // Work out the duty update for one accepted request and queue it
    function void take_request(bit w, logic signed [15:0] goal, logic signed [15:0] count);
      longint g, c, scale, goal_s, e, e1, e2, sum, inc, nd;
      ipid_res_t r;
      g = longint'(goal);
      c = longint'(count);
      scale  = w ? (1 + steer) : (1 - steer);
      goal_s = clip16(scale * g);
      e      = clip16(goal_s - c);
      e1     = err1[w];
      e2     = err2[w];
      sum = gain_p * (e - e1) + gain_i * e + gain_d * (e - 2 * e1 + e2);
      inc = sum / 256;  // signed division truncates toward zero
      err2[w] = e1;
      err1[w] = e;
      nd = acc[w] + inc;
      if (nd > upper) nd = upper;
      if (nd < lower) nd = lower;
      acc[w] = nd;
      // hold the direction while the duty sits at zero
      if (nd != 0) dir[w] = (nd < 0);
      r.wheel_out     = w;
      r.duty          = nd[15:0];
      r.pwm_magnitude = (nd < 0) ? 16'(-nd) : 16'(nd);
      r.reverse       = dir[w];
      duty_due.push_back(r);
    endfunction

    function void check_duty(bit w, logic [15:0] duty, logic [15:0] mag, bit rev);
      ipid_res_t x;
      if (duty_due.size() == 0) begin
        $error("result with no request outstanding: wheel %0d duty %0d", w, $signed(duty));
        mismatches++;
        return;
      end
      x = duty_due.pop_front();
      if (x.wheel_out !== w) begin
        $error("wheel_out: expected %0d, got %0d", x.wheel_out, w);
        mismatches++;
      end
      if (x.duty !== duty) begin
        $error("duty: expected %0d, got %0d", x.duty, $signed(duty));
        mismatches++;
      end
      if (x.pwm_magnitude !== mag) begin
        $error("pwm_magnitude: expected %0d, got %0d", x.pwm_magnitude, mag);
        mismatches++;
      end
      if (x.reverse !== rev) begin
        $error("reverse: expected %0d, got %0d", x.reverse, rev);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return duty_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;   // speed_goal, encoder_count
  logic                  s_tuser;   // wheel
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;   // duty, pwm_magnitude, reverse
  logic                  m_tuser;   // wheel_out
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  duty_predictor model;
  int long_hold;
  int dense_left;

  incremental_pid_wheel_speed DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #12_000_000;
    $display("incremental_pid_wheel_speed verification failed");
    $finish;
  end

  // Check every result taken from the output
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      model.check_duty(m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[32]);
    end
  end

  // Drive the output ready: bursts of full rate, coin flips and sparse
  // acceptance, with an occasional long hold-off
  initial begin : receiver
    int burst_left;
    int rx_mode;
    m_tready   = 1'b0;
    burst_left = 0;
    rx_mode    = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        m_tready = 1'b0;
        long_hold--;
      end else begin
        if (burst_left == 0) begin
          rx_mode    = $urandom_range(0, 2);
          burst_left = $urandom_range(4, 40);
          if ($urandom_range(0, 60) == 0) long_hold = $urandom_range(20, 80);
        end
        burst_left--;
        case (rx_mode)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          default: m_tready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Offer one request and wait for it to be taken
  task automatic offer(input bit w, input logic signed [15:0] goal,
                       input logic signed [15:0] count);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = w;
    s_tdata  = {count, goal};
    do @(posedge clk); while (!s_tready);
    model.take_request(w, goal, count);
  endtask

  // Drop valid for a gap whose length is given by n
  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      s_tuser  = 1'($urandom_range(0, 1));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Mostly short gaps, a few long ones, and dense stretches with none
  function automatic int sender_gap();
    int pick;
    if (dense_left > 0) begin
      dense_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) dense_left = $urandom_range(10, 40);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Wait until every result has come back, with a margin for latency
  task automatic settle();
    pause(1);
    while (model.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    model.write_reg(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = 16'($urandom);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 6000));
    endcase
  endfunction

  // Load a fresh random configuration, extremes included
  task automatic random_config();
    logic [15:0] steer_v, upper_v, lower_v;
    int pick;
    steer_v = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8) - 4) : 16'($urandom);
    pick = $urandom_range(0, 9);
    upper_v = (pick < 8) ? 16'($urandom_range(500, 12000)) :
              (pick == 8) ? 16'hFFFF : 16'($urandom);
    pick = $urandom_range(0, 9);
    case (pick)
      7: lower_v = 16'h8000;
      8: lower_v = 16'h0000;
      9: lower_v = 16'($urandom);
      default: lower_v = 16'(-$urandom_range(0, 12000));
    endcase
    write_reg(CFG_GAIN_P, pick_gain());
    write_reg(CFG_GAIN_I, pick_gain());
    write_reg(CFG_GAIN_D, pick_gain());
    write_reg(CFG_STEER, steer_v);
    write_reg(CFG_DUTY_UPPER, upper_v);
    write_reg(CFG_DUTY_LOWER, lower_v);
    write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, 16'($urandom));
    end_writes();
  endtask

  // One random request: goals mostly moderate, counts mostly tracking the goal
  task automatic random_request();
    int goal_v, count_v;
    bit w;
    w = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      7: goal_v = $urandom;
      8: goal_v = $urandom_range(0, 1) ? 32767 : -32768;
      9: goal_v = 0;
      default: goal_v = $urandom_range(0, 4000) - 2000;
    endcase
    case ($urandom_range(0, 9))
      6, 7: count_v = $urandom;
      8: count_v = $urandom_range(0, 1) ? 32767 : -32768;
      9: count_v = 0;
      default: count_v = goal_v + $urandom_range(0, 200) - 100;
    endcase
    offer(w, 16'(goal_v), 16'(count_v));
  endtask

  initial begin : stimulus
    model      = new();
    long_hold  = 0;
    dense_left = 0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset configuration: idle request, error saturation both ways
    offer(1'b0, 16'sd0, 16'sd0);
    offer(1'b1, 16'sd32767, -16'sd32768);
    offer(1'b0, -16'sd32768, 16'sd32767);
    offer(1'b1, -16'sd32768, 16'sd32767);
    offer(1'b1, 16'sd32767, -16'sd32768);
    settle();

    // Zero duty: pin both limits to zero so the direction must hold
    write_reg(CFG_DUTY_UPPER, 16'd0);
    write_reg(CFG_DUTY_LOWER, 16'd0);
    end_writes();
    offer(1'b0, 16'sd5, 16'sd0);
    offer(1'b1, -16'sd5, 16'sd0);
    settle();

    // Full gains and limits, steer at its top: scaled goals overflow
    write_reg(CFG_GAIN_P, 16'hFFFF);
    write_reg(CFG_GAIN_I, 16'hFFFF);
    write_reg(CFG_GAIN_D, 16'hFFFF);
    write_reg(CFG_STEER, 16'h0007);
    write_reg(CFG_DUTY_UPPER, 16'hFFFF);
    write_reg(CFG_DUTY_LOWER, 16'h8000);
    end_writes();
    offer(1'b1, 16'sd32767, 16'sd0);
    offer(1'b0, 16'sd32767, -16'sd32768);
    offer(1'b0, -16'sd32768, 16'sd32767);
    offer(1'b1, -16'sd32768, -16'sd32768);
    settle();

    // Steer at its bottom, derivative only
    write_reg(CFG_STEER, 16'hFFF8);
    write_reg(CFG_GAIN_P, 16'h0000);
    write_reg(CFG_GAIN_I, 16'h0000);
    end_writes();
    offer(1'b0, 16'sd4096, 16'sd0);
    offer(1'b1, 16'sd4096, 16'sd0);
    offer(1'b0, -16'sd4096, 16'sd0);
    settle();

    // Crossed limits, lower above upper; unknown indexes must not disturb
    write_reg(CFG_GAIN_P, GAIN_P_RESET);
    write_reg(CFG_GAIN_I, GAIN_I_RESET);
    write_reg(CFG_DUTY_UPPER, 16'd100);
    write_reg(CFG_DUTY_LOWER, 16'd500);
    write_reg(CFG_UNUSED_LO, 16'hFFFF);
    write_reg(CFG_UNUSED_HI, 16'h5A5A);
    end_writes();
    offer(1'b0, 16'sd1, 16'sd2);
    offer(1'b1, -16'sd7, 16'sd9);
    offer(1'b1, 16'sd3000, -16'sd3000);
    settle();

    // Random phases; the first opens with a long output hold-off so the
    // block fills up and stalls its input
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      if (p == 0) long_hold = 150;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pause(sender_gap());
        random_request();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("incremental_pid_wheel_speed verification clean");
    end else begin
      $display("incremental_pid_wheel_speed verification failed");
    end
    $finish;
  end

endmodule
